@@ src/bgf_pkg.sv @@
// ----------------------------------------------------------------------------
// bgf_pkg
// Types, constants and the hash distance function of the burst group finder.
// ----------------------------------------------------------------------------
package bgf_pkg;

	localparam int PHOTOS_DEF = 32;
	localparam int TAG_W      = 16;
	localparam int TIME_W     = 40;
	localparam int HASH_W     = 64;
	localparam int WIN_W      = 32;
	localparam int LIM_W      = 7;
	localparam int GRP_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_LIMIT  = 2'd1;

	localparam logic [WIN_W-1:0] WINDOW_RST = 32'd2;
	localparam logic [LIM_W-1:0] LIMIT_RST  = 7'd10;

	localparam logic KIND_MEMBER = 1'b0;
	localparam logic KIND_END    = 1'b1;

	typedef struct packed {
		logic [TAG_W-1:0]  photo_tag;
		logic              has_capture_time;
		logic [TIME_W-1:0] capture_seconds;
		logic [TIME_W-1:0] created_seconds;
		logic [HASH_W-1:0] photo_hash;
		logic              last_photo;
	} photo_in_t;

	typedef struct packed {
		logic             record_kind;
		logic [GRP_W-1:0] group_number;
		logic [TAG_W-1:0] member_tag;
		logic             group_end;
	} group_out_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic              cap_flag;
		logic [TIME_W-1:0] cap_time;
		logic [TIME_W-1:0] cre_time;
		logic [HASH_W-1:0] hash;
	} rec_t;

	typedef struct packed {
		logic a_first;
		logic gap_over;
		logic hash_near;
	} cmp_res_t;

	function automatic logic [LIM_W-1:0] hash_dist(input logic [HASH_W-1:0] v);
		logic [3:0]       b;
		logic [LIM_W-1:0] s;
		s = '0;
		for (int y = 0; y < 8; y++) begin
			b = '0;
			for (int x = 0; x < 8; x++) begin
				b = b + 4'(v[y*8+x]);
			end
			s = s + LIM_W'(b);
		end
		return s;
	endfunction

endpackage

@@ src/bgf_rec_mem.sv @@
// ----------------------------------------------------------------------------
// bgf_rec_mem
// Photo record store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bgf_rec_mem import bgf_pkg::*; #(
	parameter int DEPTH = PHOTOS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  rec_t                     wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output rec_t                     rdata_a,
	output rec_t                     rdata_b
);

	rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ src/bgf_cmp.sv @@
// ----------------------------------------------------------------------------
// bgf_cmp
// Shared compare unit: time order, time gap check and hash distance check.
// ----------------------------------------------------------------------------
module bgf_cmp import bgf_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  rec_t             rec_a,
	input  rec_t             rec_b,
	input  logic [WIN_W-1:0] window,
	input  logic [LIM_W-1:0] limit,
	output cmp_res_t         res
);

	logic              both;
	logic [TIME_W-1:0] ta;
	logic [TIME_W-1:0] tb;
	logic [TIME_W-1:0] gap;
	logic [TIME_W-1:0] gap_s1;
	logic [HASH_W-1:0] xor_s1;

	always_comb begin
		both = rec_a.cap_flag & rec_b.cap_flag;
		ta   = both ? rec_a.cap_time : rec_a.cre_time;
		tb   = both ? rec_b.cap_time : rec_b.cre_time;
		gap  = (ta >= tb) ? (ta - tb) : (tb - ta);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gap_s1 <= gap;
			xor_s1 <= rec_a.hash ^ rec_b.hash;
		end
	end

	assign res.a_first   = ta < tb;
	assign res.gap_over  = gap_s1 > TIME_W'(window);
	assign res.hash_near = hash_dist(xor_s1) <= limit;

endmodule

@@ src/burst_group_finder_unit.sv @@
// ----------------------------------------------------------------------------
// burst_group_finder_unit
// Loads photo records, sorts them by time and emits greedy burst groups.
// ----------------------------------------------------------------------------
// Records load at one per cycle. The item with last_photo set starts a
// sort and grouping pass, if the set holds two or more records, run by one
// sequencer around a single compare unit and the record store. For each
// compared entry the insertion sort reads the order store, then the record
// store, then compares; each shifted entry takes a check and a write step.
// Grouping reads the order store, then the record store, then decides for
// each tested pair. Input is not ready during the pass. Each member item
// leaves when the next member is found, the last one when its group closes,
// and a stalled output holds the pass. Input is ready again once the end
// item is loaded into the output register.
// ----------------------------------------------------------------------------
module burst_group_finder_unit import bgf_pkg::*; #(
	parameter int PHOTOS = PHOTOS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  photo_in_t             in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output group_out_t            out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = $clog2(PHOTOS);
	localparam int CW = $clog2(PHOTOS + 1);

	typedef enum logic [4:0] {
		ST_LOAD, ST_S_START, ST_S_SO, ST_S_REC, ST_S_CMP, ST_H_CHK, ST_H_WR,
		ST_G_TOP, ST_G_SO, ST_G_REC, ST_G_J, ST_GJ_SO, ST_GJ_REC, ST_GJ_DEC,
		ST_G_DONE, ST_FIN
	} state_t;

	state_t            state_q;
	logic [WIN_W-1:0]  window_q;
	logic [LIM_W-1:0]  limit_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     k_q;
	logic [CW-1:0]     placed_q;
	logic [CW-1:0]     s_q;
	logic [CW-1:0]     p_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     j_q;
	logic [GRP_W-1:0]  groups_q;
	logic [PHOTOS-1:0] visited_q;
	logic [IW-1:0]     last_q;
	logic [IW-1:0]     cand_q;
	logic [TAG_W-1:0]  pend_tag_q;
	logic [TAG_W-1:0]  cand_tag_q;
	logic              multi_q;
	logic              out_valid_q;
	group_out_t        out_item_q;

	logic [IW-1:0] so_mem [PHOTOS];
	logic [IW-1:0] so_rdata_q;
	logic          so_we;
	logic [IW-1:0] so_waddr;
	logic [IW-1:0] so_wdata;
	logic [IW-1:0] so_raddr;

	logic          rec_we;
	rec_t          rec_wdata;
	logic [IW-1:0] rec_raddr_a;
	logic [IW-1:0] rec_raddr_b;
	rec_t          rec_rdata_a;
	rec_t          rec_rdata_b;
	cmp_res_t      cmp_res;

	logic          in_acc;
	logic          out_free;
	logic          out_load;
	logic [CW-1:0] n_new;

	assign in_ready  = (state_q == ST_LOAD);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign in_acc    = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;
	assign n_new     = (cnt_q < CW'(PHOTOS)) ? CW'(cnt_q + 1'b1) : cnt_q;

	always_comb begin
		out_load = 1'b0;
		unique case (state_q)
			ST_GJ_DEC: out_load = out_free & ~cmp_res.gap_over & cmp_res.hash_near;
			ST_G_DONE: out_load = out_free & multi_q;
			ST_FIN:    out_load = out_free;
			default: ;
		endcase
	end

	assign rec_we = in_acc & (cnt_q < CW'(PHOTOS));
	always_comb begin
		rec_wdata.tag      = in_item.photo_tag;
		rec_wdata.cap_flag = in_item.has_capture_time;
		rec_wdata.cap_time = in_item.capture_seconds;
		rec_wdata.cre_time = in_item.created_seconds;
		rec_wdata.hash     = in_item.photo_hash;
	end

	always_comb begin
		rec_raddr_a = '0;
		rec_raddr_b = '0;
		so_raddr    = '0;
		so_we       = 1'b0;
		so_waddr    = s_q[IW-1:0];
		so_wdata    = so_rdata_q;
		unique case (state_q)
			ST_S_SO: so_raddr = s_q[IW-1:0];
			ST_S_REC: begin
				rec_raddr_a = k_q[IW-1:0];
				rec_raddr_b = so_rdata_q;
			end
			ST_H_CHK: begin
				if (s_q == p_q) begin
					so_we    = 1'b1;
					so_wdata = k_q[IW-1:0];
				end else begin
					so_raddr = IW'(s_q - 1'b1);
				end
			end
			ST_H_WR: so_we = 1'b1;
			ST_G_TOP: so_raddr = i_q[IW-1:0];
			ST_G_SO: rec_raddr_a = so_rdata_q;
			ST_G_J: so_raddr = j_q[IW-1:0];
			ST_GJ_SO: begin
				rec_raddr_a = last_q;
				rec_raddr_b = so_rdata_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (so_we) begin
			so_mem[so_waddr] <= so_wdata;
		end
		so_rdata_q <= so_mem[so_raddr];
	end

	bgf_rec_mem #(.DEPTH(PHOTOS)) u_rec_mem (
		.clk     (clk),
		.we      (rec_we),
		.waddr   (cnt_q[IW-1:0]),
		.wdata   (rec_wdata),
		.raddr_a (rec_raddr_a),
		.raddr_b (rec_raddr_b),
		.rdata_a (rec_rdata_a),
		.rdata_b (rec_rdata_b)
	);

	bgf_cmp u_cmp (
		.clk     (clk),
		.en      (state_q == ST_GJ_REC),
		.rec_a   (rec_rdata_a),
		.rec_b   (rec_rdata_b),
		.window  (window_q),
		.limit   (limit_q),
		.res     (cmp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
			limit_q  <= LIMIT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_TIME_WINDOW) begin
				window_q <= cfg_data[WIN_W-1:0];
			end else if (cfg_index == CFG_HASH_LIMIT) begin
				limit_q <= cfg_data[LIM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			k_q         <= '0;
			placed_q    <= '0;
			s_q         <= '0;
			p_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			groups_q    <= '0;
			visited_q   <= '0;
			last_q      <= '0;
			cand_q      <= '0;
			pend_tag_q  <= '0;
			cand_tag_q  <= '0;
			multi_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			out_valid_q <= out_load | (out_valid_q & ~out_ready);
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						cnt_q <= n_new;
						if (in_item.last_photo) begin
							visited_q <= '0;
							groups_q  <= '0;
							k_q       <= '0;
							placed_q  <= '0;
							i_q       <= '0;
							state_q   <= (n_new >= CW'(2)) ? ST_S_START : ST_FIN;
						end
					end
				end
				ST_S_START: begin
					s_q <= '0;
					if (placed_q == '0) begin
						p_q     <= '0;
						state_q <= ST_H_CHK;
					end else begin
						state_q <= ST_S_SO;
					end
				end
				ST_S_SO:  state_q <= ST_S_REC;
				ST_S_REC: state_q <= ST_S_CMP;
				ST_S_CMP: begin
					if (cmp_res.a_first) begin
						p_q     <= s_q;
						s_q     <= placed_q;
						state_q <= ST_H_CHK;
					end else if (CW'(s_q + 1'b1) == placed_q) begin
						p_q     <= placed_q;
						s_q     <= placed_q;
						state_q <= ST_H_CHK;
					end else begin
						s_q     <= CW'(s_q + 1'b1);
						state_q <= ST_S_SO;
					end
				end
				ST_H_CHK: begin
					if (s_q == p_q) begin
						placed_q <= CW'(placed_q + 1'b1);
						k_q      <= CW'(k_q + 1'b1);
						state_q  <= (CW'(k_q + 1'b1) == cnt_q) ? ST_G_TOP : ST_S_START;
					end else begin
						state_q <= ST_H_WR;
					end
				end
				ST_H_WR: begin
					s_q     <= CW'(s_q - 1'b1);
					state_q <= ST_H_CHK;
				end
				ST_G_TOP: begin
					if (i_q == cnt_q) begin
						state_q <= ST_FIN;
					end else if (visited_q[i_q[IW-1:0]]) begin
						i_q <= CW'(i_q + 1'b1);
					end else begin
						visited_q[i_q[IW-1:0]] <= 1'b1;
						state_q <= ST_G_SO;
					end
				end
				ST_G_SO: begin
					last_q  <= so_rdata_q;
					state_q <= ST_G_REC;
				end
				ST_G_REC: begin
					pend_tag_q <= rec_rdata_a.tag;
					multi_q    <= 1'b0;
					j_q        <= CW'(i_q + 1'b1);
					state_q    <= ST_G_J;
				end
				ST_G_J: begin
					if (j_q == cnt_q) begin
						state_q <= ST_G_DONE;
					end else if (visited_q[j_q[IW-1:0]]) begin
						j_q <= CW'(j_q + 1'b1);
					end else begin
						state_q <= ST_GJ_SO;
					end
				end
				ST_GJ_SO: begin
					cand_q  <= so_rdata_q;
					state_q <= ST_GJ_REC;
				end
				ST_GJ_REC: begin
					cand_tag_q <= rec_rdata_b.tag;
					state_q    <= ST_GJ_DEC;
				end
				ST_GJ_DEC: begin
					if (cmp_res.gap_over) begin
						state_q <= ST_G_DONE;
					end else if (!cmp_res.hash_near) begin
						j_q     <= CW'(j_q + 1'b1);
						state_q <= ST_G_J;
					end else if (out_free) begin
						out_item_q.record_kind  <= KIND_MEMBER;
						out_item_q.group_number <= groups_q;
						out_item_q.member_tag   <= pend_tag_q;
						out_item_q.group_end    <= 1'b0;
						multi_q                 <= 1'b1;
						visited_q[j_q[IW-1:0]]  <= 1'b1;
						last_q                  <= cand_q;
						pend_tag_q              <= cand_tag_q;
						j_q                     <= CW'(j_q + 1'b1);
						state_q                 <= ST_G_J;
					end
				end
				ST_G_DONE: begin
					if (!multi_q) begin
						i_q     <= CW'(i_q + 1'b1);
						state_q <= ST_G_TOP;
					end else if (out_free) begin
						out_item_q.record_kind  <= KIND_MEMBER;
						out_item_q.group_number <= groups_q;
						out_item_q.member_tag   <= pend_tag_q;
						out_item_q.group_end    <= 1'b1;
						groups_q                <= GRP_W'(groups_q + 1'b1);
						i_q                     <= CW'(i_q + 1'b1);
						state_q                 <= ST_G_TOP;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_item_q.record_kind  <= KIND_END;
						out_item_q.group_number <= groups_q;
						out_item_q.member_tag   <= '0;
						out_item_q.group_end    <= 1'b0;
						cnt_q                   <= '0;
						state_q                 <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

@@ src/bgf_checker.sv @@
// ----------------------------------------------------------------------------
// bgf_props
// Port-level checks of the burst group finder, bound to the top level.
// ----------------------------------------------------------------------------
module bgf_props import bgf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input photo_in_t  in_item,
	input logic       out_valid,
	input logic       out_ready,
	input group_out_t out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.record_kind == KIND_END |->
			out_item.member_tag == '0 && !out_item.group_end)
		else $error("end item carries member fields");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.last_photo |=> !in_ready)
		else $error("input ready right after final record");

	a_member_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.record_kind == KIND_MEMBER |-> !in_ready)
		else $error("member item pending while loading");

endmodule

bind burst_group_finder_unit bgf_props u_bgf_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

@@ verif/bgf_checker.sv @@
// ----------------------------------------------------------------------------
// bgf_checker
// Watches the photo, group and register channels of the burst group finder.
// It keeps its own copy of the record store and the registers, builds the
// expected groups when a set closes, and compares every result item with
// the oldest expected one.
// ----------------------------------------------------------------------------
module bgf_checker import bgf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  photo_in_t             in_item,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  group_out_t            out_item,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    err_count,
	output int                    pending
);

	localparam int DEPTH = PHOTOS_DEF;

	rec_t             album [DEPTH];
	int               stored;
	logic [WIN_W-1:0] window;
	logic [LIM_W-1:0] limit;
	group_out_t       group_q [$];

	function automatic void enqueue_expected(input group_out_t r);
		group_q = {group_q, r};
	endfunction

	function automatic logic both_cap(int a, int b);
		return album[a].cap_flag && album[b].cap_flag;
	endfunction

	function automatic logic earlier(int a, int b);
		if (both_cap(a, b)) begin
			return album[a].cap_time < album[b].cap_time;
		end
		return album[a].cre_time < album[b].cre_time;
	endfunction

	function automatic logic [TIME_W-1:0] gap(int a, int b);
		logic [TIME_W-1:0] ta, tb;
		ta = both_cap(a, b) ? album[a].cap_time : album[a].cre_time;
		tb = both_cap(a, b) ? album[b].cap_time : album[b].cre_time;
		return (ta >= tb) ? ta - tb : tb - ta;
	endfunction

	task automatic build_groups();
		int         order [DEPTH];
		bit         seen [DEPTH];
		int         members [DEPTH];
		int         p, cnt, last, groups;
		group_out_t r;
		groups = 0;
		if (stored >= 2) begin
			for (int k = 0; k < stored; k++) begin
				p = k;
				for (int s = 0; s < k; s++) begin
					if (earlier(k, order[s])) begin
						p = s;
						break;
					end
				end
				for (int s = k; s > p; s--) order[s] = order[s-1];
				order[p] = k;
			end
			for (int i = 0; i < stored; i++) seen[i] = 0;
			for (int i = 0; i < stored; i++) begin
				if (seen[i]) continue;
				seen[i] = 1;
				cnt = 1;
				members[0] = order[i];
				for (int j = i + 1; j < stored; j++) begin
					if (seen[j]) continue;
					last = members[cnt-1];
					if ({24'd0, gap(order[j], last)} > {32'd0, window}) break;
					if ($countones(album[last].hash ^ album[order[j]].hash) <= limit) begin
						members[cnt] = order[j];
						cnt++;
						seen[j] = 1;
					end
				end
				if (cnt >= 2) begin
					for (int m = 0; m < cnt; m++) begin
						r.record_kind  = KIND_MEMBER;
						r.group_number = GRP_W'(groups);
						r.member_tag   = album[members[m]].tag;
						r.group_end    = (m == cnt - 1);
						enqueue_expected(r);
					end
					groups++;
				end
			end
		end
		r.record_kind  = KIND_END;
		r.group_number = GRP_W'(groups);
		r.member_tag   = '0;
		r.group_end    = 1'b0;
		enqueue_expected(r);
		stored = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		group_out_t want;
		if (!arst_n) begin
			stored    = 0;
			window    = WINDOW_RST;
			limit     = LIMIT_RST;
			err_count = 0;
			group_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_TIME_WINDOW) window = cfg_data[WIN_W-1:0];
				else if (cfg_index == CFG_HASH_LIMIT) limit = cfg_data[LIM_W-1:0];
			end
			if (in_valid && in_ready) begin
				if (stored < DEPTH) begin
					album[stored].tag      = in_item.photo_tag;
					album[stored].cap_flag = in_item.has_capture_time;
					album[stored].cap_time = in_item.capture_seconds;
					album[stored].cre_time = in_item.created_seconds;
					album[stored].hash     = in_item.photo_hash;
					stored++;
				end
				if (in_item.last_photo) build_groups();
			end
			if (out_valid && out_ready) begin
				if (group_q.size() == 0) begin
					$display("%0t: unexpected result item %h", $time, out_item);
					err_count++;
				end else begin
					want = group_q.pop_front();
					if (want.record_kind !== out_item.record_kind ||
					    want.group_number !== out_item.group_number ||
					    want.member_tag !== out_item.member_tag ||
					    want.group_end !== out_item.group_end) begin
						$display("%0t: mismatch expected kind=%0d grp=%0d tag=%h end=%0d",
							$time, want.record_kind, want.group_number,
							want.member_tag, want.group_end);
						$display("%0t:          actual   kind=%0d grp=%0d tag=%h end=%0d",
							$time, out_item.record_kind, out_item.group_number,
							out_item.member_tag, out_item.group_end);
						err_count++;
					end
				end
			end
		end
		pending = group_q.size();
	end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives photo sets and register writes into the burst group finder under
// several idle and stall patterns, with a long output hold-off, and reports
// the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module testbench import bgf_pkg::*;;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 40000;
	localparam int HOLD_CYCLES = 400;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	photo_in_t             in_item = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	group_out_t            out_item;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    err_count;
	int                    pending;

	int send_idle = 0;
	int recv_stall = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet = 0;
	int sent = 0;

	always #5 clk = ~clk;

	burst_group_finder_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bgf_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.err_count(err_count), .pending(pending)
	);

	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic send_photo(input photo_in_t p);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= p;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic photo_in_t photo(input logic [TAG_W-1:0] tag, input logic cap,
		input logic [TIME_W-1:0] ct, input logic [TIME_W-1:0] cr,
		input logic [HASH_W-1:0] h, input logic last);
		photo_in_t p;
		p.photo_tag        = tag;
		p.has_capture_time = cap;
		p.capture_seconds  = ct;
		p.created_seconds  = cr;
		p.photo_hash       = h;
		p.last_photo       = last;
		return p;
	endfunction

	function automatic logic [TIME_W-1:0] rand_base();
		logic [TIME_W-1:0] t;
		t = {8'($urandom), 32'($urandom)};
		if (t > 40'hFF_FFFF_F000) t = t - 40'h1000;
		if (t < 40'h1000) t = t + 40'h1000;
		return t;
	endfunction

	// one burst-like set: times mostly drift slowly, hashes are mostly near copies of a base
	task automatic burst_set(input int n);
		logic [TIME_W-1:0] ct, cr;
		logic [HASH_W-1:0] hb, flips;
		ct = rand_base();
		cr = rand_base();
		hb = {$urandom, $urandom};
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				ct = ct + 40'($urandom_range(0, 50));
				cr = cr + 40'($urandom_range(0, 50));
			end else begin
				ct = ct + 40'($urandom_range(0, 4)) - 40'd1;
				cr = cr + 40'($urandom_range(0, 4)) - 40'd1;
			end
			case ($urandom_range(0, 3))
				0: flips = '0;
				1: flips = {$urandom, $urandom};
				default: flips = {$urandom & $urandom & $urandom, $urandom & $urandom & $urandom};
			endcase
			send_photo(photo(16'($urandom), $urandom_range(0, 3) != 0, ct, cr, hb ^ flips,
				k == n - 1));
		end
	endtask

	task automatic run_phase(input int items, input bit full_set, input bit pressure);
		int goal;
		goal = sent + items;
		if (full_set) burst_set(PHOTOS_DEF + 2);
		while (sent < goal) begin
			if (pressure) begin
				hold_req++;
				pressure = 0;
			end
			burst_set($urandom_range(0, 7) == 0 ? $urandom_range(9, 16) : $urandom_range(1, 8));
		end
		settle();
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single record, and two zero records that differ only in tag
		send_photo(photo(16'hFFFF, 1'b1, '1, '1, '1, 1'b1));
		send_photo(photo(16'h0000, 1'b0, '0, '0, '0, 1'b0));
		send_photo(photo(16'h0001, 1'b0, '0, '0, '0, 1'b1));
		// extremes: far apart hashes, capture vs creation time
		send_photo(photo(16'hFFFF, 1'b1, '1, '0, '1, 1'b0));
		send_photo(photo(16'h8000, 1'b1, 40'hFF_FFFF_FFFE, '1, '0, 1'b0));
		send_photo(photo(16'h7FFF, 1'b0, '0, 40'h1, 64'h3FF, 1'b0));
		send_photo(photo(16'h1234, 1'b1, 40'hFF_FFFF_FFFD, 40'h2, 64'h7FF, 1'b0));
		send_photo(photo(16'h4321, 1'b0, '1, 40'h3, 64'h1, 1'b1));
		// out of order times with mixed capture flags
		send_photo(photo(16'h0010, 1'b1, 40'd100, 40'd50, 64'hF0, 1'b0));
		send_photo(photo(16'h0011, 1'b0, 40'd99, 40'd49, 64'hF1, 1'b0));
		send_photo(photo(16'h0012, 1'b1, 40'd98, 40'd51, 64'hF3, 1'b0));
		send_photo(photo(16'h0013, 1'b1, 40'd101, 40'd48, 64'hF0, 1'b0));
		send_photo(photo(16'h0014, 1'b0, 40'd0, 40'd50, 64'hF2, 1'b1));
		settle();

		write_reg(CFG_TIME_WINDOW, 32'd5);
		write_reg(CFG_HASH_LIMIT, 32'd12);
		run_phase(50, 0, 0);

		send_idle = 84;
		write_reg(CFG_TIME_WINDOW, 32'd0);
		write_reg(CFG_HASH_LIMIT, 32'd0);
		write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
		write_reg(CFG_SPARE, 32'd1);
		run_phase(50, 1, 0);

		send_idle = 0;
		recv_stall = 84;
		write_reg(CFG_TIME_WINDOW, 32'hFFFF_FFFF);
		write_reg(CFG_HASH_LIMIT, 32'hFFFF_FF7F);
		run_phase(50, 0, 1);

		send_idle = 18;
		recv_stall = 18;
		write_reg(CFG_TIME_WINDOW, 32'($urandom_range(1, 10)));
		write_reg(CFG_HASH_LIMIT, 32'd64);
		run_phase(50, 0, 0);

		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ burst_group_finder_unit.f @@
src/bgf_pkg.sv
src/bgf_rec_mem.sv
src/bgf_cmp.sv
src/burst_group_finder_unit.sv
src/bgf_checker.sv
verif/bgf_checker.sv
verif/testbench.sv
